@@ sv/pair_table_layout_chooser_macros.svh @@
// Assertion macros used by the checker file of the layout chooser.
`ifndef PAIR_TABLE_LAYOUT_CHOOSER_MACROS_SVH
`define PAIR_TABLE_LAYOUT_CHOOSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define PTLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ptlc_pkg.sv @@
// Types, constants and helper functions of the pair table layout chooser.
package ptlc_pkg;

  // Statistics counter width and fixed field widths
  localparam int COUNT_BITS = 32;
  localparam int VAL_W      = 63;
  localparam int CFG_W      = 32;
  localparam int BYTES_W    = 4;
  localparam int SUM_W      = BYTES_W + 1;
  localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int PROD_W     = COUNT_BITS + SUM_W + 1;
  localparam int CFG_IDX_W  = 2;

  // Longest run that still fits one-byte counts, and the narrow and wide count sizes
  localparam logic [COUNT_BITS-1:0] RUN_SHORT_MAX = COUNT_BITS'(255);
  localparam logic [BYTES_W-1:0]    COUNT_NARROW_BYTES = BYTES_W'(1);
  localparam logic [BYTES_W-1:0]    COUNT_WIDE_BYTES   = BYTES_W'(4);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_ROW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_FOR_LARGE   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] GROUP_LIMIT_RESET     = CFG_W'(65536);
  localparam logic [CFG_W-1:0] EXACT_ROW_LIMIT_RESET = CFG_W'(1048576);

  // Byte-width codes
  localparam logic [1:0] WCODE_1     = 2'd0;
  localparam logic [1:0] WCODE_2     = 2'd1;
  localparam logic [1:0] WCODE_4     = 2'd2;
  localparam logic [1:0] WCODE_5PLUS = 2'd3;

  typedef enum logic [1:0] {
    LAYOUT_COLUMN  = 2'd0,
    LAYOUT_ROW     = 2'd1,
    LAYOUT_CLUSTER = 2'd2
  } layout_t;

  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic [VAL_W-1:0]      max_first;
    logic [VAL_W-1:0]      max_second;
    logic [COUNT_BITS-1:0] run_count;
    logic [COUNT_BITS-1:0] row_count;
    logic                  long_run;
  } stats_t;

  typedef struct packed {
    logic [CFG_W-1:0] group_limit;
    logic [CFG_W-1:0] exact_row_limit;
    logic             row_for_large;
  } cfg_t;

  typedef struct packed {
    logic       exact;
    logic       wide_count;
    logic [1:0] second_width_code;
    logic [1:0] first_width_code;
    layout_t    layout;
  } result_t;

  // Least number of bytes, 1 to 8, that holds the value
  function automatic logic [BYTES_W-1:0] byte_count(input logic [VAL_W-1:0] v);
    logic [BYTES_W-1:0] n;
    n = BYTES_W'(1);
    for (int i = 1; i < 8; i++) begin
      if ((v >> (8 * i)) != '0) n = BYTES_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [1:0] width_code(input logic [BYTES_W-1:0] n);
    logic [1:0] c;
    case (n)
      4'd1:        c = WCODE_1;
      4'd2:        c = WCODE_2;
      4'd3, 4'd4:  c = WCODE_4;
      default:     c = WCODE_5PLUS;
    endcase
    return c;
  endfunction

  // Saturating counter increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

@@ sv/ptlc_stats.sv @@
// Running table statistics: maxima, run tracking and row count.
module ptlc_stats
  import ptlc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  pair_t  item,
  input  logic   go,
  output stats_t stats_next
);

  logic [VAL_W-1:0]      max_first;
  logic [VAL_W-1:0]      max_second;
  logic [VAL_W-1:0]      previous_first;
  logic                  have_previous;
  logic [COUNT_BITS-1:0] run_count;
  logic [COUNT_BITS-1:0] current_run;
  logic [COUNT_BITS-1:0] longest_run;
  logic [COUNT_BITS-1:0] row_count;

  logic [VAL_W-1:0]      max_first_next;
  logic [VAL_W-1:0]      max_second_next;
  logic                  new_run;
  logic [COUNT_BITS-1:0] run_count_next;
  logic [COUNT_BITS-1:0] current_run_next;
  logic [COUNT_BITS-1:0] longest_run_next;
  logic [COUNT_BITS-1:0] row_count_next;

  // Fold the current pair into the statistics
  always_comb begin
    max_first_next   = (item.first > max_first) ? item.first : max_first;
    max_second_next  = (item.second > max_second) ? item.second : max_second;
    new_run          = !have_previous || (item.first != previous_first);
    run_count_next   = new_run ? sat_inc(run_count) : run_count;
    current_run_next = sat_inc(new_run ? '0 : current_run);
    longest_run_next = (current_run_next > longest_run) ? current_run_next : longest_run;
    row_count_next   = sat_inc(row_count);

    stats_next.max_first  = max_first_next;
    stats_next.max_second = max_second_next;
    stats_next.run_count  = run_count_next;
    stats_next.row_count  = row_count_next;
    stats_next.long_run   = longest_run_next > RUN_SHORT_MAX;
  end

  // Advance on each beat; clear after the last beat of a table
  always_ff @(posedge clk) begin
    if (rst || (go && item.last)) begin
      max_first      <= '0;
      max_second     <= '0;
      previous_first <= '0;
      have_previous  <= 1'b0;
      run_count      <= '0;
      current_run    <= '0;
      longest_run    <= '0;
      row_count      <= '0;
    end else if (go) begin
      max_first      <= max_first_next;
      max_second     <= max_second_next;
      previous_first <= item.first;
      have_previous  <= 1'b1;
      run_count      <= run_count_next;
      current_run    <= current_run_next;
      longest_run    <= longest_run_next;
      row_count      <= row_count_next;
    end
  end

endmodule

@@ sv/ptlc_decide.sv @@
// Layout decision from the final statistics of a table.
module ptlc_decide
  import ptlc_pkg::*;
(
  input  stats_t  stats,
  input  cfg_t    cfg,
  output result_t result
);

  logic [BYTES_W-1:0] b1;
  logic [BYTES_W-1:0] b2;
  logic [BYTES_W-1:0] bc;
  logic [PROD_W-1:0]  row_bytes;
  logic [PROD_W-1:0]  clu_bytes;
  logic               below_limit;
  logic               many_runs;

  always_comb begin
    b1 = byte_count(stats.max_first);
    b2 = byte_count(stats.max_second);
    bc = stats.long_run ? COUNT_WIDE_BYTES : COUNT_NARROW_BYTES;

    // Estimated byte totals of the row and cluster layouts
    row_bytes = PROD_W'(stats.row_count) * PROD_W'(SUM_W'(b1) + SUM_W'(b2));
    clu_bytes = PROD_W'(stats.run_count) * PROD_W'(SUM_W'(b1) + SUM_W'(bc))
              + PROD_W'(b2);

    below_limit = CMP_W'(stats.row_count) < CMP_W'(cfg.exact_row_limit);
    many_runs   = CMP_W'(stats.run_count) >= CMP_W'(cfg.group_limit);

    result.layout            = LAYOUT_COLUMN;
    result.first_width_code  = WCODE_1;
    result.second_width_code = WCODE_1;
    result.wide_count        = 1'b0;
    result.exact             = 1'b1;

    if (!below_limit) begin
      // Table too large for exact statistics: fixed layout
      result.exact = 1'b0;
      if (cfg.row_for_large) begin
        result.layout            = LAYOUT_ROW;
        result.first_width_code  = WCODE_5PLUS;
        result.second_width_code = WCODE_5PLUS;
      end
    end else if (!many_runs) begin
      result.first_width_code  = width_code(b1);
      result.second_width_code = width_code(b2);
      if (row_bytes < clu_bytes) begin
        result.layout = LAYOUT_ROW;
      end else begin
        result.layout     = LAYOUT_CLUSTER;
        result.wide_count = stats.long_run;
      end
    end
  end

endmodule

@@ sv/pair_table_layout_chooser.sv @@
// Top level of the pair table layout chooser: input, snapshot and result registers.
//
//  channel  dir  handshake                data
//  s_*      in   s_tvalid / s_tready      s_tdata pair, s_tlast last pair of table
//  m_*      out  m_tvalid / m_tready      m_tdata layout and width codes
//  cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pair per cycle unless a last beat waits for a free snapshot; the statistics update on each accepted pair.
// A table's last beat passes the input register, the snapshot and then the result
// register before its result appears on m_tvalid.
// Synchronous reset clears all valid bits and statistics and reloads the configuration reset values.
// With results waiting in both the snapshot and the result register, the next
// last beat holds in the input register and blocks the input; pairs ahead of it flow.
module pair_table_layout_chooser
  import ptlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [127:0]         s_tdata,   // first_value[62:0], second_value[125:63], zeros
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // layout[1:0], first_width_code[3:2],
                                          // second_width_code[5:4], wide_count[6], exact[7]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  logic    in_valid;
  pair_t   in_item;
  logic    snap_valid;
  stats_t  snap;
  stats_t  stats_next;
  logic    out_valid;
  result_t out_result;
  result_t result;

  logic out_free;
  logic snap_go;
  logic snap_free;
  logic stats_go;

  // Pipeline flow control
  assign out_free  = !out_valid || m_tready;
  assign snap_go   = snap_valid && out_free;
  assign snap_free = !snap_valid || snap_go;
  assign stats_go  = in_valid && (!in_item.last || snap_free);
  assign s_tready  = !in_valid || stats_go;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_limit     <= GROUP_LIMIT_RESET;
      cfg.exact_row_limit <= EXACT_ROW_LIMIT_RESET;
      cfg.row_for_large   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GROUP_LIMIT:     cfg.group_limit     <= cfg_data;
        CFG_EXACT_ROW_LIMIT: cfg.exact_row_limit <= cfg_data;
        CFG_ROW_FOR_LARGE:   cfg.row_for_large   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: take a beat whenever the stage drains
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.first  <= s_tdata[VAL_W-1:0];
      in_item.second <= s_tdata[2*VAL_W-1:VAL_W];
      in_item.last   <= s_tlast;
    end
  end

  ptlc_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .item       (in_item),
    .go         (stats_go),
    .stats_next (stats_next)
  );

  // Snapshot of the final statistics of a table
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= stats_go && in_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_free && stats_go && in_item.last) begin
      snap <= stats_next;
    end
  end

  ptlc_decide u_decide (
    .stats  (snap),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_go;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_go) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_result;

endmodule

@@ sv/ptlc_checker.sv @@
// Port-level assertions for the pair table layout chooser, bound to the top level.
`include "pair_table_layout_chooser_macros.svh"

module ptlc_checker
  import ptlc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Stalled result beat holds
  `PTLC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // Reset empties the pipeline
  `PTLC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && s_tready, "pipeline not empty after reset")

  // Column results carry no width codes
  `PTLC_ASSERT(a_column_codes, m_tvalid && m_tdata[1:0] == LAYOUT_COLUMN |-> m_tdata[6:2] == 5'd0, "column result with nonzero codes")

  // Only cluster results can flag wide counts
  `PTLC_ASSERT(a_wide_cluster, m_tvalid && m_tdata[6] |-> m_tdata[1:0] == LAYOUT_CLUSTER && m_tdata[7], "wide count outside an exact cluster result")

  // Fallback row uses the widest codes
  `PTLC_ASSERT(a_fallback_row, m_tvalid && !m_tdata[7] && m_tdata[1:0] == LAYOUT_ROW |-> m_tdata[5:2] == 4'hf, "fallback row without widest codes")

endmodule

bind pair_table_layout_chooser ptlc_checker u_ptlc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/tb_pair_table_layout_chooser.sv @@
// Self-checking testbench for the pair table layout chooser: random tables, configs and stalls.
module tb_pair_table_layout_chooser;
  import ptlc_pkg::*;

  localparam int IDLE_PCT  = 37;
  localparam int LIMIT     = 400000;
  localparam int HOLD_AT   = 120;
  localparam int HOLD_LEN  = 300;
  localparam int PHASE_LEN = 130;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [127:0]         s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pair_table_layout_chooser u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Pairs waiting to be sent and layouts waiting to come back
  pair_t   pair_backlog[$];
  result_t layout_due[$];
  pair_t   beat;

  // Shadow statistics and registers
  logic [VAL_W-1:0]      top_first = '0, top_second = '0, prev_first = '0;
  bit                    have_prev = 1'b0;
  logic [COUNT_BITS-1:0] run_cnt = '0, cur_run = '0, longest = '0, row_cnt = '0;
  logic [CFG_W-1:0]      lim_groups = GROUP_LIMIT_RESET;
  logic [CFG_W-1:0]      lim_rows = EXACT_ROW_LIMIT_RESET;
  logic                  row_pick = 1'b0;

  int  n_in = 0, seen_in = 0, queued = 0, n_cfg = 0, errors = 0, cycles = 0;
  int  n_tables = 0, n_col = 0, n_row = 0, n_clu = 0, n_fallback = 0, n_wide = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  steady = 1'b0;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int unsigned bytes_needed(input logic [VAL_W-1:0] v);
    int unsigned n;
    n = 1;
    while (n < 8 && (v >> (8 * n)) != '0) n++;
    return n;
  endfunction

  function automatic logic [1:0] code_for(input int unsigned n);
    if (n == 1) return WCODE_1;
    if (n == 2) return WCODE_2;
    if (n < 5) return WCODE_4;
    return WCODE_5PLUS;
  endfunction

  // Fold one pair into the statistics; on the last pair queue the chosen layout
  task automatic absorb_pair(input pair_t p);
    result_t     r;
    int unsigned b1, b2, bc;
    logic [63:0] row_bytes, clu_bytes;
    if (p.first > top_first) top_first = p.first;
    if (p.second > top_second) top_second = p.second;
    if (!have_prev || p.first != prev_first) begin
      prev_first = p.first;
      have_prev = 1'b1;
      cur_run = '0;
      run_cnt = bump(run_cnt);
    end
    cur_run = bump(cur_run);
    if (cur_run > longest) longest = cur_run;
    row_cnt = bump(row_cnt);
    if (p.last) begin
      r = '0;
      r.layout = LAYOUT_COLUMN;
      r.exact = 1'b1;
      if (row_cnt < lim_rows) begin
        if (run_cnt < lim_groups) begin
          b1 = bytes_needed(top_first);
          b2 = bytes_needed(top_second);
          bc = (longest <= RUN_SHORT_MAX) ? 1 : 4;
          row_bytes = 64'(row_cnt) * 64'(b1 + b2);
          clu_bytes = 64'(run_cnt) * 64'(b1 + bc) + 64'(b2);
          r.first_width_code = code_for(b1);
          r.second_width_code = code_for(b2);
          if (row_bytes < clu_bytes) begin
            r.layout = LAYOUT_ROW;
          end else begin
            r.layout = LAYOUT_CLUSTER;
            r.wide_count = (bc > 1);
          end
        end
      end else begin
        r.exact = 1'b0;
        if (row_pick) begin
          r.layout = LAYOUT_ROW;
          r.first_width_code = WCODE_5PLUS;
          r.second_width_code = WCODE_5PLUS;
        end
      end
      layout_due = {layout_due, r};
      top_first = '0;
      top_second = '0;
      prev_first = '0;
      have_prev = 1'b0;
      run_cnt = '0;
      cur_run = '0;
      longest = '0;
      row_cnt = '0;
    end
  endtask

  // Compare one result beat against the oldest pending layout
  task automatic check_layout(input result_t got);
    result_t want;
    if (layout_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %h", got);
    end else begin
      want = layout_due.pop_front();
      n_tables++;
      if (!want.exact) n_fallback++;
      else if (want.layout == LAYOUT_COLUMN) n_col++;
      else if (want.layout == LAYOUT_ROW) n_row++;
      else n_clu++;
      if (want.wide_count) n_wide++;
      if (got.layout !== want.layout || got.first_width_code !== want.first_width_code ||
          got.second_width_code !== want.second_width_code ||
          got.wide_count !== want.wide_count || got.exact !== want.exact) begin
        errors++;
        if (errors <= 10)
          $display("layout mismatch: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                   want.layout, want.first_width_code, want.second_width_code,
                   want.wide_count, want.exact, got.layout, got.first_width_code,
                   got.second_width_code, got.wide_count, got.exact);
      end
    end
  endtask

  // Sample both streams on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        n_in++;
        absorb_pair(pair_t'({s_tdata[62:0], s_tdata[125:63], s_tlast}));
      end
      if (m_tvalid && m_tready) check_layout(result_t'(m_tdata));
    end
  end

  // Pair driver: advance on acceptance, idle at random
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || n_in != seen_in) begin
      seen_in = n_in;
      if (pair_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        beat = pair_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, beat.second, beat.first};
        s_tlast <= beat.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && n_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GROUP_LIMIT:     lim_groups = val;
      CFG_EXACT_ROW_LIMIT: lim_rows = val;
      CFG_ROW_FOR_LARGE:   row_pick = val[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pair(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                          input logic last);
    pair_t p;
    p.first = a;
    p.second = b;
    p.last = last;
    pair_backlog = {pair_backlog, p};
    queued++;
  endtask

  // Random value whose byte count is at most w, usually exactly w
  function automatic logic [VAL_W-1:0] value_of_width(input int w);
    logic [VAL_W-1:0] v;
    int               n;
    n = ($urandom_range(3) == 0) ? $urandom_range(w, 1) : w;
    v = VAL_W'({$urandom, $urandom});
    if (n < 8) v = v & ((VAL_W'(1) << (8 * n)) - 1'b1);
    if (n > 1) v[8 * (n - 1) + $urandom_range(n == 8 ? 6 : 7)] = 1'b1;
    return v;
  endfunction

  // One table: new_pct is the chance that a pair opens a new run
  task automatic add_table(input int rows, input int w1, input int w2, input int new_pct);
    logic [VAL_W-1:0] a;
    a = value_of_width(w1);
    for (int i = 0; i < rows; i++) begin
      if (i > 0 && $urandom_range(99) < new_pct) a = value_of_width(w1);
      add_pair(a, value_of_width(w2), i == rows - 1);
    end
  endtask

  // Drain everything, then let the pipeline empty out
  task automatic settle();
    while (pair_backlog.size() != 0 || s_tvalid || layout_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int start;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, width boundaries, runs and clusters at reset config
    add_pair('0, '0, 1'b1);
    add_pair('1, '1, 1'b1);
    add_pair('1, '0, 1'b1);
    add_pair('0, '1, 1'b1);
    add_pair(63'h1234, 63'h12_3456, 1'b0);
    add_pair(63'h1234, 63'h12_3456, 1'b0);
    add_pair(63'h1234, 63'h12_3456, 1'b1);
    add_pair(63'hFF, 63'hFFFF, 1'b0);
    add_pair(63'h100, 63'h1_0000, 1'b0);
    add_pair(63'hFFFF_FFFF, 63'hFF_FFFF_FFFF, 1'b1);
    add_pair(63'h1_0000_0000, 63'h1_0000_0000_0000, 1'b1);
    add_pair(63'd5, 63'd1, 1'b0);
    add_pair(63'd5, 63'd2, 1'b0);
    add_pair(63'd7, 63'd3, 1'b0);
    add_pair(63'd5, 63'd4, 1'b1);
    settle();

    for (int ph = 1; ph <= 9; ph++) begin
      steady = (ph == 7);
      case (ph)
        1: begin
          write_reg(CFG_GROUP_LIMIT, '1);
          write_reg(CFG_EXACT_ROW_LIMIT, '1);
          write_reg(CFG_ROW_FOR_LARGE, 32'hFFFF_FFFE);
        end
        2: begin
          write_reg(CFG_GROUP_LIMIT, '0);
          write_reg(CFG_EXACT_ROW_LIMIT, EXACT_ROW_LIMIT_RESET);
          write_reg(CFG_ROW_FOR_LARGE, 32'd1);
        end
        3: begin
          write_reg(CFG_GROUP_LIMIT, $urandom_range(6, 2));
          write_reg(CFG_EXACT_ROW_LIMIT, $urandom_range(40, 5));
          write_reg(CFG_ROW_FOR_LARGE, $urandom | 32'd1);
        end
        4: begin
          write_reg(CFG_GROUP_LIMIT, $urandom_range(6, 2));
          write_reg(CFG_EXACT_ROW_LIMIT, $urandom_range(40, 5));
          write_reg(CFG_ROW_FOR_LARGE, $urandom & 32'hFFFF_FFFE);
          write_reg(CFG_SPARE, $urandom);
        end
        5: begin
          write_reg(CFG_GROUP_LIMIT, 32'd1);
          write_reg(CFG_EXACT_ROW_LIMIT, 32'd1);
          write_reg(CFG_ROW_FOR_LARGE, 32'd1);
        end
        6: begin
          write_reg(CFG_GROUP_LIMIT, $urandom);
          write_reg(CFG_EXACT_ROW_LIMIT, '0);
          write_reg(CFG_ROW_FOR_LARGE, '0);
          write_reg(CFG_SPARE, $urandom);
        end
        7: begin
          write_reg(CFG_GROUP_LIMIT, GROUP_LIMIT_RESET);
          write_reg(CFG_EXACT_ROW_LIMIT, EXACT_ROW_LIMIT_RESET);
          write_reg(CFG_ROW_FOR_LARGE, '0);
        end
        8: begin
          write_reg(CFG_GROUP_LIMIT, $urandom_range(10, 3));
          write_reg(CFG_EXACT_ROW_LIMIT, $urandom_range(60, 10));
          write_reg(CFG_ROW_FOR_LARGE, $urandom);
        end
        default: begin
          write_reg(CFG_GROUP_LIMIT, $urandom);
          write_reg(CFG_EXACT_ROW_LIMIT, $urandom);
          write_reg(CFG_ROW_FOR_LARGE, $urandom);
        end
      endcase

      // Mostly short tables, a few longer ones, run density from all-new to one run
      start = queued;
      while (queued - start < PHASE_LEN)
        add_table(($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1),
                  $urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(100, 0));
      if (ph == 1)
        add_table(260 + $urandom_range(40), $urandom_range(8, 1), $urandom_range(8, 1), 2);
      if (ph == 7) begin
        // Longest run right at and just past the one-byte count limit
        add_table(255, $urandom_range(8, 1), $urandom_range(8, 1), 0);
        add_table(256, $urandom_range(8, 1), $urandom_range(8, 1), 0);
      end
      settle();
    end

    $display("%0d pairs in %0d tables over %0d register writes", n_in, n_tables, n_cfg);
    $display("column %0d, row %0d, cluster %0d, fallback %0d, wide counts %0d, errors %0d",
             n_col, n_row, n_clu, n_fallback, n_wide, errors);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/ptlc_pkg.sv
sv/ptlc_stats.sv
sv/ptlc_decide.sv
sv/pair_table_layout_chooser.sv
sv/ptlc_checker.sv
sim/tb_pair_table_layout_chooser.sv
